### design/riotc_pkg.sv
// Shared types, codes and helpers for the RAM/IO/timer chip.
`default_nettype none
package riotc_pkg;

   localparam int unsigned RAM_DEPTH_DEFAULT = 128;

   // request kinds
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   // address decode bits
   localparam int unsigned SEL_IO_BIT       = 9;
   localparam int unsigned SEL_INTERVAL_BIT = 4;
   localparam int unsigned SEL_IRQ_BIT      = 3;
   localparam int unsigned SEL_TIMER_BIT    = 2;
   localparam int unsigned SEL_STATUS_BIT   = 0;

   // port register select, address bits 1..0
   localparam logic [1:0] PORT_A_DATA = 2'd0;
   localparam logic [1:0] PORT_A_DIR  = 2'd1;
   localparam logic [1:0] PORT_B_DATA = 2'd2;
   localparam logic [1:0] PORT_B_DIR  = 2'd3;

   localparam logic [7:0] TIMER_RESET  = 8'h77;
   localparam logic [1:0] DIVIDE_RESET = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [9:0] addr;
      logic [7:0] data;
      logic [7:0] pa;
      logic [7:0] pb;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] a_drive;
      logic [7:0] a_dir;
      logic [7:0] b_drive;
      logic [7:0] b_dir;
      logic       a_changed;
      logic       timer_flag;
      logic       edge_flag;
   } rsp_item_type;

   typedef struct packed {
      logic       en;
      logic [9:0] addr;
      logic [7:0] data;
   } ram_wr_type;

   function automatic logic [10:0] divisor(input logic [1:0] sel);
      logic [10:0] d;
      case (sel)
         2'd0:    d = 11'd1;
         2'd1:    d = 11'd8;
         2'd2:    d = 11'd64;
         default: d = 11'd1024;
      endcase
      return d;
   endfunction

   // addr modulo depth by binary-weighted subtraction; depth >= 64 keeps addr < 16*depth
   function automatic logic [9:0] ram_index(input logic [9:0] addr, input int unsigned depth);
      logic [11:0] r;
      logic [11:0] step;
      r = {2'b00, addr};
      for (int k = 3; k >= 0; k--) begin
         step = 12'(depth << k);
         if (r >= step) r = r - step;
      end
      return r[9:0];
   endfunction

endpackage
`default_nettype wire

### design/riotc_ram.sv
// Scratch RAM with per-entry valid bits and write-to-read bypass.
`default_nettype none
module riotc_ram #(
   parameter int unsigned RAM_DEPTH = riotc_pkg::RAM_DEPTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rd_en,
   input  wire logic [9:0]             rd_addr,
   input  wire riotc_pkg::ram_wr_type  wr,
   output logic [7:0]                  rd_data
);
   import riotc_pkg::*;

   localparam int unsigned IDX_W = $clog2(RAM_DEPTH);

   logic [7:0]           mem [RAM_DEPTH];
   logic [RAM_DEPTH-1:0] vld_ff;
   logic [7:0]           mem_q_ff;
   logic                 q_vld_ff;
   logic                 byp_ff;
   logic [7:0]           byp_data_ff;
   logic [9:0]           rd_full;
   logic [9:0]           wr_full;
   logic [IDX_W-1:0]     rd_idx;
   logic [IDX_W-1:0]     wr_idx;

   assign rd_full = ram_index(rd_addr, RAM_DEPTH);
   assign wr_full = ram_index(wr.addr, RAM_DEPTH);
   assign rd_idx  = rd_full[IDX_W-1:0];
   assign wr_idx  = wr_full[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) mem[wr_idx] <= wr.data;
      if (rd_en) begin
         mem_q_ff    <= mem[rd_idx];
         byp_data_ff <= wr.data;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         q_vld_ff <= 1'b0;
         byp_ff   <= 1'b0;
      end else begin
         if (wr.en) vld_ff[wr_idx] <= 1'b1;
         if (rd_en) begin
            q_vld_ff <= vld_ff[rd_idx];
            byp_ff   <= wr.en && (wr_idx == rd_idx);
         end
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : (q_vld_ff ? mem_q_ff : 8'h00);

   wr_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr.en |=> vld_ff[$past(wr_idx)])
      else $error("written RAM entry not marked valid");

endmodule
`default_nettype wire

### design/riotc_core.sv
// Port, timer and edge-detect registers with their per-transaction update.
`default_nettype none
module riotc_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    commit,
   input  wire riotc_pkg::req_item_type item,
   input  wire logic [7:0]              ram_rd_data,
   output riotc_pkg::ram_wr_type        ram_wr,
   output riotc_pkg::rsp_item_type      result
);
   import riotc_pkg::*;

   logic [7:0] a_out_ff, a_out_in, a_dir_ff, a_dir_in;
   logic [7:0] b_out_ff, b_out_in, b_dir_ff, b_dir_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [1:0] div_sel_ff, div_sel_in;
   logic [9:0] phase_ff, phase_in;
   logic       uf_ff, uf_in, wrapped_ff, wrapped_in;
   logic       cirq_ff, cirq_in, rising_ff, rising_in;
   logic       eirq_ff, eirq_in, edge_ff, edge_in, last_b7_ff, last_b7_in;

   logic [7:0]  rd;
   logic        changed;
   logic [10:0] div_cur;
   logic [10:0] div_new;
   logic [10:0] phase_inc;
   logic [7:0]  cnt_dec;

   always_comb begin
      a_out_in   = a_out_ff;
      a_dir_in   = a_dir_ff;
      b_out_in   = b_out_ff;
      b_dir_in   = b_dir_ff;
      cnt_in     = cnt_ff;
      div_sel_in = div_sel_ff;
      phase_in   = phase_ff;
      uf_in      = uf_ff;
      wrapped_in = wrapped_ff;
      cirq_in    = cirq_ff;
      rising_in  = rising_ff;
      eirq_in    = eirq_ff;
      edge_in    = edge_ff;
      last_b7_in = last_b7_ff;
      rd         = 8'h00;
      changed    = 1'b0;
      ram_wr     = '0;
      div_cur    = divisor(div_sel_ff);
      div_new    = divisor(item.addr[1:0]);
      phase_inc  = {1'b0, phase_ff} + 11'd1;
      cnt_dec    = cnt_ff - 8'd1;

      unique case (item.kind)
         REQ_TICK: begin
            if (item.pa[7] != last_b7_ff) begin
               if (item.pa[7] == rising_ff) edge_in = 1'b1;
               last_b7_in = item.pa[7];
            end
            wrapped_in = 1'b0;
            phase_in   = (phase_inc >= div_cur) ? 10'd0 : phase_inc[9:0];
            if (uf_ff) begin
               cnt_in = cnt_dec;
               if (cnt_dec == 8'hFF) wrapped_in = 1'b1;
            end else if (phase_in == 10'd0) begin
               if (cnt_ff == 8'h00) begin
                  uf_in      = 1'b1;
                  wrapped_in = 1'b1;
               end
               cnt_in = cnt_dec;
            end
         end
         REQ_READ: begin
            if (!item.addr[SEL_IO_BIT]) begin
               rd = ram_rd_data;
            end else if (!item.addr[SEL_TIMER_BIT]) begin
               unique case (item.addr[1:0])
                  PORT_A_DATA: rd = (a_out_ff & a_dir_ff) | (item.pa & ~a_dir_ff);
                  PORT_A_DIR:  rd = a_dir_ff;
                  PORT_B_DATA: rd = (b_out_ff & b_dir_ff) | (item.pb & ~b_dir_ff);
                  default:     rd = b_dir_ff;
               endcase
            end else if (item.addr[SEL_STATUS_BIT]) begin
               rd      = {uf_ff, edge_ff, 6'b000000};
               edge_in = 1'b0;
            end else begin
               // a wrap on the previous tick keeps the flag set
               if (!wrapped_ff) uf_in = 1'b0;
               rd = cnt_ff;
            end
         end
         REQ_WRITE: begin
            if (!item.addr[SEL_IO_BIT]) begin
               ram_wr.en   = commit;
               ram_wr.addr = item.addr;
               ram_wr.data = item.data;
            end else if (!item.addr[SEL_TIMER_BIT]) begin
               unique case (item.addr[1:0])
                  PORT_A_DATA: begin
                     a_out_in = item.data;
                     changed  = 1'b1;
                  end
                  PORT_A_DIR: begin
                     a_dir_in = item.data;
                     changed  = 1'b1;
                  end
                  PORT_B_DATA: b_out_in = item.data;
                  default:     b_dir_in = item.data;
               endcase
            end else if (item.addr[SEL_INTERVAL_BIT]) begin
               div_sel_in = item.addr[1:0];
               phase_in   = 10'(div_new - 11'd1);
               cnt_in     = item.data;
               uf_in      = 1'b0;
               cirq_in    = item.addr[SEL_IRQ_BIT];
            end else begin
               rising_in = item.addr[0];
               eirq_in   = item.addr[SEL_IRQ_BIT];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_out_ff   <= 8'h00;
         a_dir_ff   <= 8'h00;
         b_out_ff   <= 8'h00;
         b_dir_ff   <= 8'h00;
         cnt_ff     <= TIMER_RESET;
         div_sel_ff <= DIVIDE_RESET;
         phase_ff   <= 10'd0;
         uf_ff      <= 1'b0;
         wrapped_ff <= 1'b0;
         cirq_ff    <= 1'b0;
         rising_ff  <= 1'b0;
         eirq_ff    <= 1'b0;
         edge_ff    <= 1'b0;
         last_b7_ff <= 1'b1;
      end else if (commit) begin
         a_out_ff   <= a_out_in;
         a_dir_ff   <= a_dir_in;
         b_out_ff   <= b_out_in;
         b_dir_ff   <= b_dir_in;
         cnt_ff     <= cnt_in;
         div_sel_ff <= div_sel_in;
         phase_ff   <= phase_in;
         uf_ff      <= uf_in;
         wrapped_ff <= wrapped_in;
         cirq_ff    <= cirq_in;
         rising_ff  <= rising_in;
         eirq_ff    <= eirq_in;
         edge_ff    <= edge_in;
         last_b7_ff <= last_b7_in;
      end
   end

   always_comb begin
      result.read_data  = rd;
      result.a_drive    = a_out_in;
      result.a_dir      = a_dir_in;
      result.b_drive    = b_out_in;
      result.b_dir      = b_dir_in;
      result.a_changed  = changed;
      result.timer_flag = uf_in;
      result.edge_flag  = edge_in;
   end

   phase_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, phase_ff} < divisor(div_sel_ff))
      else $error("prescaler phase outside divisor");

endmodule
`default_nettype wire

### design/ram_io_timer_chip_unit.sv
// Top level of the RAM/IO/timer chip: handshake, input stage and result register.
// Usage:
//   Request channel (req_*): one transaction per request, timer tick, bus read or bus write,
//   with the port A and port B pin levels sampled alongside it.
//   Result channel (rsp_*): one result per request, in order: read data plus
//   the port registers, the port A change strobe and both status flags.
// Result path: an accepted request passes through the input stage, which also
//   issues the RAM read, then the result register, which drives rsp_valid.
// Throughput: one transaction per cycle unless rsp_stall holds a result; the RAM
//   is written when a transaction leaves the input stage and a same-address read
//   in the following request is bypassed, so there is no bubble.
// Reset: ports and flags clear, timer 0x77 at divide by 1024; RAM entries read
//   as zero until written (per-entry valid bits, no clearing pass).
// Stall: when rsp_stall holds a pending result, the input stage keeps its
//   transaction and req_stall rises once that stage is full; nothing is lost.
`default_nettype none
module ram_io_timer_chip_unit #(
   parameter int unsigned RAM_DEPTH = riotc_pkg::RAM_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_type,
   input  wire logic [9:0] req_bus_addr,
   input  wire logic [7:0] req_write_data,
   input  wire logic [7:0] req_port_a_pins,
   input  wire logic [7:0] req_port_b_pins,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_read_data,
   output logic [7:0]      rsp_port_a_drive,
   output logic [7:0]      rsp_port_a_dir,
   output logic [7:0]      rsp_port_b_drive,
   output logic [7:0]      rsp_port_b_dir,
   output logic            rsp_port_a_changed,
   output logic            rsp_timer_flag,
   output logic            rsp_edge_flag_out
);
   import riotc_pkg::*;

   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_ff;
   logic         advance;
   logic         req_accept;
   ram_wr_type   ram_wr;
   logic [7:0]   ram_rd_data;
   rsp_item_type result;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept)   s1_valid_ff <= 1'b1;
         else if (advance) s1_valid_ff <= 1'b0;
         if (advance)        rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff.kind <= req_type;
         s1_item_ff.addr <= req_bus_addr;
         s1_item_ff.data <= req_write_data;
         s1_item_ff.pa   <= req_port_a_pins;
         s1_item_ff.pb   <= req_port_b_pins;
      end
      if (advance) rsp_ff <= result;
   end

   riotc_ram #(
      .RAM_DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (req_bus_addr),
      .wr      (ram_wr),
      .rd_data (ram_rd_data)
   );

   riotc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .commit      (advance),
      .item        (s1_item_ff),
      .ram_rd_data (ram_rd_data),
      .ram_wr      (ram_wr),
      .result      (result)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_ff.read_data;
   assign rsp_port_a_drive   = rsp_ff.a_drive;
   assign rsp_port_a_dir     = rsp_ff.a_dir;
   assign rsp_port_b_drive   = rsp_ff.b_drive;
   assign rsp_port_b_dir     = rsp_ff.b_dir;
   assign rsp_port_a_changed = rsp_ff.a_changed;
   assign rsp_timer_flag     = rsp_ff.timer_flag;
   assign rsp_edge_flag_out  = rsp_ff.edge_flag;

   stall_needs_full_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with empty input stage");

   accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted transaction missing from input stage");

   advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("transaction left input stage without a result");

   ram_write_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      ram_wr.en |-> advance)
      else $error("RAM written outside a commit");

endmodule
`default_nettype wire

### tb/tb_ram_io_timer_chip_unit.sv
// Self-checking testbench for the RAM/IO/timer chip: queued stimulus, transaction-level predictor.
`timescale 1ns / 1ps
module tb_ram_io_timer_chip_unit;
   import riotc_pkg::*;

   localparam int RAM_WORDS      = RAM_DEPTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_CYCLES   = 20;
   localparam logic [10:0] PRESCALE_DIV [4] = '{11'd1, 11'd8, 11'd64, 11'd1024};

   logic       clock           = 1'b0;
   logic       reset           = 1'b1;
   logic       req_valid       = 1'b0;
   logic       req_stall;
   logic [1:0] req_type        = REQ_TICK;
   logic [9:0] req_bus_addr    = '0;
   logic [7:0] req_write_data  = '0;
   logic [7:0] req_port_a_pins = '0;
   logic [7:0] req_port_b_pins = '0;
   logic       rsp_valid;
   logic       rsp_stall       = 1'b0;
   logic [7:0] rsp_read_data;
   logic [7:0] rsp_port_a_drive;
   logic [7:0] rsp_port_a_dir;
   logic [7:0] rsp_port_b_drive;
   logic [7:0] rsp_port_b_dir;
   logic       rsp_port_a_changed;
   logic       rsp_timer_flag;
   logic       rsp_edge_flag_out;

   ram_io_timer_chip_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_bus_addr       (req_bus_addr),
      .req_write_data     (req_write_data),
      .req_port_a_pins    (req_port_a_pins),
      .req_port_b_pins    (req_port_b_pins),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_port_a_drive   (rsp_port_a_drive),
      .rsp_port_a_dir     (rsp_port_a_dir),
      .rsp_port_b_drive   (rsp_port_b_drive),
      .rsp_port_b_dir     (rsp_port_b_dir),
      .rsp_port_a_changed (rsp_port_a_changed),
      .rsp_timer_flag     (rsp_timer_flag),
      .rsp_edge_flag_out  (rsp_edge_flag_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // chip state as the predictor tracks it
   logic [7:0]  scratch [RAM_WORDS];
   logic [7:0]  a_out, a_dir, b_out, b_dir;
   logic [7:0]  tmr_count;
   logic [1:0]  div_sel;
   logic [10:0] tmr_phase;
   logic        underflow, wrapped, cnt_irq_en, rising_sel, edge_irq_en, edge_seen, last_b7;

   req_item_type pending_req_q [$];
   rsp_item_type expected_rsp_q [$];
   req_item_type drv_item;

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   bit want_hold      = 1'b0;
   int queued_cnt     = 0;
   int accepted_cnt   = 0;
   int checked_cnt    = 0;
   int mismatch_cnt   = 0;
   int underflow_hits = 0;
   int edge_hits      = 0;

   function automatic rsp_item_type predict_chip_response(input req_item_type it);
      rsp_item_type r;
      logic         b7;
      int           idx;
      r   = '0;
      idx = int'(it.addr) % RAM_WORDS;
      case (it.kind)
         REQ_TICK: begin
            b7 = it.pa[7];
            if (b7 != last_b7) begin
               if (b7 == rising_sel) begin
                  edge_seen = 1'b1;
                  edge_hits++;
               end
               last_b7 = b7;
            end
            wrapped   = 1'b0;
            tmr_phase = tmr_phase + 11'd1;
            if (tmr_phase >= PRESCALE_DIV[div_sel])
               tmr_phase = '0;
            if (underflow) begin
               tmr_count = tmr_count - 8'd1;
               if (tmr_count == 8'hFF)
                  wrapped = 1'b1;
            end else if (tmr_phase == 0) begin
               if (tmr_count == 8'h00) begin
                  underflow = 1'b1;
                  wrapped   = 1'b1;
                  underflow_hits++;
               end
               tmr_count = tmr_count - 8'd1;
            end
         end
         REQ_READ: begin
            if (!it.addr[SEL_IO_BIT]) begin
               r.read_data = scratch[idx];
            end else if (!it.addr[SEL_TIMER_BIT]) begin
               case (it.addr[1:0])
                  PORT_A_DATA: r.read_data = (a_out & a_dir) | (it.pa & ~a_dir);
                  PORT_A_DIR:  r.read_data = a_dir;
                  PORT_B_DATA: r.read_data = (b_out & b_dir) | (it.pb & ~b_dir);
                  default:     r.read_data = b_dir;
               endcase
            end else if (it.addr[SEL_STATUS_BIT]) begin
               r.read_data = {underflow, edge_seen, 6'b0};
               edge_seen   = 1'b0;
            end else begin
               // a read on the very tick of the wrap leaves the flag standing
               if (!wrapped)
                  underflow = 1'b0;
               r.read_data = tmr_count;
            end
         end
         REQ_WRITE: begin
            if (!it.addr[SEL_IO_BIT]) begin
               scratch[idx] = it.data;
            end else if (!it.addr[SEL_TIMER_BIT]) begin
               case (it.addr[1:0])
                  PORT_A_DATA: begin
                     a_out       = it.data;
                     r.a_changed = 1'b1;
                  end
                  PORT_A_DIR: begin
                     a_dir       = it.data;
                     r.a_changed = 1'b1;
                  end
                  PORT_B_DATA: b_out = it.data;
                  default:     b_dir = it.data;
               endcase
            end else if (it.addr[SEL_INTERVAL_BIT]) begin
               div_sel    = it.addr[1:0];
               tmr_phase  = PRESCALE_DIV[div_sel] - 11'd1;
               tmr_count  = it.data;
               underflow  = 1'b0;
               cnt_irq_en = it.addr[SEL_IRQ_BIT];
            end else begin
               rising_sel  = it.addr[0];
               edge_irq_en = it.addr[SEL_IRQ_BIT];
            end
         end
         default: ;
      endcase
      r.a_drive    = a_out;
      r.a_dir      = a_dir;
      r.b_drive    = b_out;
      r.b_dir      = b_dir;
      r.timer_flag = underflow;
      r.edge_flag  = edge_seen;
      return r;
   endfunction

   task automatic push_req(input logic [1:0] kind, input logic [9:0] addr,
                           input logic [7:0] data, input logic [7:0] pa, input logic [7:0] pb);
      req_item_type it;
      it.kind = kind;
      it.addr = addr;
      it.data = data;
      it.pa   = pa;
      it.pb   = pb;
      pending_req_q.push_back(it);
      queued_cnt++;
   endtask

   task automatic push_tick();
      push_req(REQ_TICK, 10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // timer region access with random don't-care address bits
   task automatic push_timer_access(input logic [1:0] kind, input bit status_sel,
                                    input logic [7:0] data);
      logic [9:0] a;
      a                 = 10'($urandom);
      a[SEL_IO_BIT]     = 1'b1;
      a[SEL_TIMER_BIT]  = 1'b1;
      a[SEL_STATUS_BIT] = status_sel;
      push_req(kind, a, data, 8'($urandom), 8'($urandom));
   endtask

   task automatic push_timer_load(input logic [1:0] sel, input logic [7:0] count);
      logic [9:0] a;
      a                   = 10'($urandom);
      a[SEL_IO_BIT]       = 1'b1;
      a[SEL_TIMER_BIT]    = 1'b1;
      a[SEL_INTERVAL_BIT] = 1'b1;
      a[1:0]              = sel;
      push_req(REQ_WRITE, a, count, 8'($urandom), 8'($urandom));
   endtask

   task automatic add_random_item();
      logic [1:0] kind;
      logic [9:0] a;
      logic [7:0] d;
      int         r;
      r    = $urandom_range(99);
      kind = (r < 40) ? REQ_TICK : (r < 70) ? REQ_READ : REQ_WRITE;
      a    = 10'($urandom);
      d    = 8'($urandom);
      r    = $urandom_range(9);
      if (r < 4) begin
         a[SEL_IO_BIT] = 1'b0;
      end else if (r < 7) begin
         a[SEL_IO_BIT]    = 1'b1;
         a[SEL_TIMER_BIT] = 1'b0;
      end else begin
         a[SEL_IO_BIT]    = 1'b1;
         a[SEL_TIMER_BIT] = 1'b1;
         if (kind == REQ_WRITE && a[SEL_INTERVAL_BIT]) begin
            // keep most loads short enough to reach underflow
            r      = $urandom_range(99);
            a[1:0] = (r < 60) ? 2'd0 : (r < 85) ? 2'd1 : (r < 95) ? 2'd2 : 2'd3;
            if ($urandom_range(99) < 70)
               d = 8'($urandom_range(6));
         end
      end
      push_req(kind, a, d, 8'($urandom), 8'($urandom));
   endtask

   task automatic add_timer_burst();
      int n;
      push_timer_load(2'($urandom_range(1)), 8'($urandom_range(5)));
      n = $urandom_range(14, 1);
      repeat (n) begin
         if ($urandom_range(99) < 25)
            push_timer_access(REQ_READ, 1'($urandom), 8'($urandom));
         push_tick();
      end
      push_timer_access(REQ_READ, 1'b0, 8'($urandom));
      if ($urandom_range(1))
         push_timer_access(REQ_READ, 1'b1, 8'($urandom));
   endtask

   task automatic add_edge_burst();
      logic [9:0] a;
      int         n;
      a                   = 10'($urandom);
      a[SEL_IO_BIT]       = 1'b1;
      a[SEL_TIMER_BIT]    = 1'b1;
      a[SEL_INTERVAL_BIT] = 1'b0;
      push_req(REQ_WRITE, a, 8'($urandom), 8'($urandom), 8'($urandom));
      n = $urandom_range(8, 2);
      repeat (n)
         push_tick();
      push_timer_access(REQ_READ, 1'b1, 8'($urandom));
   endtask

   task automatic add_random_phase(input int n);
      int start;
      int r;
      start = queued_cnt;
      while (queued_cnt - start < n) begin
         r = $urandom_range(99);
         if (r < 20)
            add_timer_burst();
         else if (r < 32)
            add_edge_burst();
         else
            add_random_item();
      end
   endtask

   task automatic wait_sent();
      while (pending_req_q.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(predict_chip_response(drv_item));
            accepted_cnt++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_item        = pending_req_q.pop_front();
               req_valid       <= 1'b1;
               req_type        <= drv_item.kind;
               req_bus_addr    <= drv_item.addr;
               req_write_data  <= drv_item.data;
               req_port_a_pins <= drv_item.pa;
               req_port_b_pins <= drv_item.pb;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result stall: random, plus one long hold-off to back the block up
   always @(posedge clock) begin : stall_gen
      int  hold_left;
      bit  hold_taken;
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_left  = 0;
         hold_taken = 1'b0;
      end else if (want_hold && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // result monitor and watchdog
   always @(posedge clock) begin : rsp_monitor
      rsp_item_type got;
      rsp_item_type want;
      int           quiet_cycles;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_read_data, rsp_port_a_drive, rsp_port_a_dir, rsp_port_b_drive,
                   rsp_port_b_dir, rsp_port_a_changed, rsp_timer_flag, rsp_edge_flag_out};
            checked_cnt++;
            if (expected_rsp_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("ERROR t=%0t: result with no transaction outstanding: %h", $time, got);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got !== want) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10) begin
                     $write("ERROR t=%0t result %0d: rd exp %h got %h",
                            $time, checked_cnt, want.read_data, got.read_data);
                     $write(" | A drv/dir exp %h/%h got %h/%h",
                            want.a_drive, want.a_dir, got.a_drive, got.a_dir);
                     $write(" | B drv/dir exp %h/%h got %h/%h",
                            want.b_drive, want.b_dir, got.b_drive, got.b_dir);
                     $display(" | chg/tmr/edge exp %b%b%b got %b%b%b",
                              want.a_changed, want.timer_flag, want.edge_flag,
                              got.a_changed, got.timer_flag, got.edge_flag);
                  end
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else if (req_valid || pending_req_q.size() != 0 || expected_rsp_q.size() != 0)
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_rsp_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      for (int i = 0; i < RAM_WORDS; i++)
         scratch[i] = 8'h00;
      a_out       = '0;
      a_dir       = '0;
      b_out       = '0;
      b_dir       = '0;
      tmr_count   = TIMER_RESET;
      div_sel     = DIVIDE_RESET;
      tmr_phase   = '0;
      underflow   = 1'b0;
      wrapped     = 1'b0;
      cnt_irq_en  = 1'b0;
      rising_sel  = 1'b0;
      edge_irq_en = 1'b0;
      edge_seen   = 1'b0;
      last_b7     = 1'b1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: RAM extremes and address aliasing
      push_req(REQ_WRITE, 10'h000, 8'hFF, 8'h00, 8'h00);
      push_req(REQ_WRITE, 10'h07F, 8'h5A, 8'hFF, 8'hFF);
      push_req(REQ_READ,  10'h17F, 8'h00, 8'h00, 8'h00);
      push_req(REQ_READ,  10'h080, 8'h00, 8'h00, 8'h00);
      push_req(REQ_READ,  10'h045, 8'h00, 8'h00, 8'h00);
      // port registers, with mixed direction on reads
      push_req(REQ_WRITE, 10'h200, 8'hA5, 8'h00, 8'h00);
      push_req(REQ_WRITE, 10'h201, 8'hF0, 8'h00, 8'h00);
      push_req(REQ_WRITE, 10'h3FA, 8'h3C, 8'h00, 8'h00);
      push_req(REQ_WRITE, 10'h203, 8'hFF, 8'h00, 8'h00);
      push_req(REQ_READ,  10'h200, 8'h00, 8'h0F, 8'hFF);
      push_req(REQ_READ,  10'h201, 8'h00, 8'h00, 8'h00);
      push_req(REQ_READ,  10'h202, 8'h00, 8'h00, 8'h55);
      push_req(REQ_READ,  10'h203, 8'h00, 8'hFF, 8'hFF);
      // edge detect: rising mode ignores the fall, catches the rise
      push_req(REQ_WRITE, 10'h205, 8'h00, 8'h00, 8'h00);
      push_req(REQ_TICK,  10'h000, 8'h00, 8'h00, 8'h00);
      push_req(REQ_TICK,  10'h3FF, 8'hFF, 8'h80, 8'hFF);
      push_req(REQ_READ,  10'h285, 8'h00, 8'h00, 8'h00);
      push_req(REQ_WRITE, 10'h20C, 8'h00, 8'h00, 8'h00);
      // timer: load 0 at divide 1, counter read on the wrap tick keeps the flag
      push_req(REQ_WRITE, 10'h214, 8'h00, 8'h00, 8'h00);
      push_req(REQ_TICK,  10'h000, 8'h00, 8'h00, 8'h00);
      push_req(REQ_READ,  10'h204, 8'h00, 8'h00, 8'h00);
      push_req(REQ_TICK,  10'h000, 8'h00, 8'h00, 8'h00);
      push_req(REQ_READ,  10'h3FD, 8'h00, 8'h00, 8'h00);
      push_req(REQ_READ,  10'h204, 8'h00, 8'h00, 8'h00);
      push_req(REQ_WRITE, 10'h21F, 8'hFF, 8'h00, 8'h00);

      // phase 0: back to back, with a long result hold-off
      want_hold = 1'b1;
      // full lap of the free-running count so it wraps again while flagged
      push_timer_load(2'd0, 8'h00);
      repeat (257) push_tick();
      push_timer_access(REQ_READ, 1'b0, 8'h00);
      push_timer_access(REQ_READ, 1'b1, 8'h00);
      push_tick();
      push_timer_access(REQ_READ, 1'b0, 8'h00);
      wait_sent();

      send_idle_pct = 73;
      stall_pct     = 0;
      add_random_phase(256);
      wait_sent();

      send_idle_pct = 0;
      stall_pct     = 73;
      add_random_phase(256);
      wait_sent();

      send_idle_pct = 12;
      stall_pct     = 12;
      add_random_phase(256);
      wait_sent();

      while (expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d transactions sent, %0d results checked over four idle/stall mixes",
               accepted_cnt, checked_cnt);
      $display("Summary: %0d timer underflows, %0d port A bit 7 edges, %0d mismatches",
               underflow_hits, edge_hits, mismatch_cnt);
      if (mismatch_cnt == 0 && expected_rsp_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
